// File: rtl/qmr_pkg.sv
package qmr_pkg;

    localparam int DW = 16;            // data width
    localparam int FB = 14;            // fraction bits
    localparam int OW = DW + 1;        // operand width, holds an exact negation
    localparam int PW = 2 * OW;        // product width
    localparam int AW = PW + 2;        // accumulator width for four products plus rounding

    localparam logic CMD_MUL = 1'b0;
    localparam logic CMD_ROT = 1'b1;

    typedef logic signed [DW-1:0] data_t;
    typedef logic signed [OW-1:0] opnd_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [AW-1:0] acc_t;

    localparam data_t DATA_MAX = data_t'({1'b0, {(DW-1){1'b1}}});
    localparam data_t DATA_MIN = data_t'({1'b1, {(DW-1){1'b0}}});
    localparam acc_t  ROUND_HALF = acc_t'(1) <<< (FB - 1);

    // Hamilton product terms: component k, term j uses a[TERM_A] * b[TERM_B]
    localparam logic [1:0] TERM_A [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd2, 2'd3, 2'd1},
        '{2'd0, 2'd3, 2'd1, 2'd2}
    };
    localparam logic [1:0] TERM_B [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd2, 2'd0, 2'd1, 2'd3},
        '{2'd3, 2'd0, 2'd2, 2'd1}
    };
    localparam logic TERM_NEG [4][4] = '{
        '{1'b0, 1'b1, 1'b1, 1'b1},
        '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b0, 1'b0, 1'b1}
    };

endpackage

// File: rtl/qmr_prod.sv
module qmr_prod (
    input  logic           clk,
    input  logic           en,
    input  qmr_pkg::opnd_t a   [4],
    input  qmr_pkg::opnd_t b   [4],
    output qmr_pkg::prod_t prod[4][4]
);

    qmr_pkg::prod_t prod_reg [4][4];
    qmr_pkg::prod_t prod_next[4][4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod_next[k][j] = a[qmr_pkg::TERM_A[k][j]] * b[qmr_pkg::TERM_B[k][j]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// File: rtl/qmr_rsum.sv
module qmr_rsum (
    input  logic           clk,
    input  logic           en,
    input  qmr_pkg::prod_t prod[4][4],
    output qmr_pkg::data_t res [4],
    output logic [3:0]     sat
);

    qmr_pkg::data_t res_reg [4];
    qmr_pkg::data_t res_next[4];
    logic [3:0]     sat_reg;
    logic [3:0]     sat_next;
    qmr_pkg::acc_t  sum     [4];
    qmr_pkg::acc_t  shifted [4];
    logic [qmr_pkg::AW-qmr_pkg::DW:0] upper [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sum[k] = qmr_pkg::ROUND_HALF;
            for (int j = 0; j < 4; j++)
            begin
                if (qmr_pkg::TERM_NEG[k][j])
                    sum[k] = sum[k] - qmr_pkg::acc_t'(prod[k][j]);
                else
                    sum[k] = sum[k] + qmr_pkg::acc_t'(prod[k][j]);
            end
            shifted[k] = sum[k] >>> qmr_pkg::FB;
            // in range when every bit above the result's sign matches it
            upper[k] = shifted[k][qmr_pkg::AW-1:qmr_pkg::DW-1];
            if ((upper[k] == '0) || (upper[k] == '1))
            begin
                res_next[k] = shifted[k][qmr_pkg::DW-1:0];
                sat_next[k] = 1'b0;
            end
            else
            begin
                res_next[k] = shifted[k][qmr_pkg::AW-1] ? qmr_pkg::DATA_MIN
                                                         : qmr_pkg::DATA_MAX;
                sat_next[k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

// File: rtl/quaternion_multiply_rotate_core.sv
// Fixed-point quaternion unit, Q2.14 data.
// Input channel: in_valid / in_stall with cmd, a_w..a_z, b_w..b_z. cmd selects
// the Hamilton product a*b or the rotation of vector (b_x, b_y, b_z) by a.
// Output channel: out_valid / out_stall with r_w..r_z and saturated.
// One result per input, in order.
// Throughput: one item per cycle while out_stall is low; four pipeline stages
// (first products, first round/saturate, second products, second
// round/saturate), each holding its own valid bit, so an item can enter on every clock.
// Rotate runs both multiply passes; product bypasses the second pass.
// Stall: out_stall holds the output stage; upstream stages keep filling their
// empty slots, and in_stall rises only when the first stage is full and cannot
// advance. Nothing is dropped or repeated.
// Reset: rst_n clears all valid bits; the data and sideband registers are not reset.
module quaternion_multiply_rotate_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           cmd,
    input  qmr_pkg::data_t a_w,
    input  qmr_pkg::data_t a_x,
    input  qmr_pkg::data_t a_y,
    input  qmr_pkg::data_t a_z,
    input  qmr_pkg::data_t b_w,
    input  qmr_pkg::data_t b_x,
    input  qmr_pkg::data_t b_y,
    input  qmr_pkg::data_t b_z,
    output logic           out_valid,
    input  logic           out_stall,
    output qmr_pkg::data_t r_w,
    output qmr_pkg::data_t r_x,
    output qmr_pkg::data_t r_y,
    output qmr_pkg::data_t r_z,
    output logic           saturated
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    logic           cmd1_reg, cmd2_reg, cmd3_reg, cmd4_reg;
    qmr_pkg::data_t a1_reg [4];
    qmr_pkg::data_t a2_reg [4];
    qmr_pkg::data_t t3_reg [4];
    qmr_pkg::data_t t4_reg [4];
    logic           sat1_3_reg, sat1_4_reg;

    qmr_pkg::opnd_t op_a1 [4];
    qmr_pkg::opnd_t op_b1 [4];
    qmr_pkg::opnd_t op_a2 [4];
    qmr_pkg::opnd_t op_b2 [4];
    qmr_pkg::prod_t prod1 [4][4];
    qmr_pkg::prod_t prod2 [4][4];
    qmr_pkg::data_t t     [4];
    qmr_pkg::data_t r2    [4];
    logic [3:0]     sat1;
    logic [3:0]     sat2;

    // a stage advances when it is empty or the one after it advances
    assign en4 = !v4_reg || !out_stall;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // first pass: a * b, with b's scalar dropped for rotate
    always_comb
    begin
        op_a1[0] = qmr_pkg::opnd_t'(a_w);
        op_a1[1] = qmr_pkg::opnd_t'(a_x);
        op_a1[2] = qmr_pkg::opnd_t'(a_y);
        op_a1[3] = qmr_pkg::opnd_t'(a_z);
        op_b1[0] = (cmd == qmr_pkg::CMD_ROT) ? '0 : qmr_pkg::opnd_t'(b_w);
        op_b1[1] = qmr_pkg::opnd_t'(b_x);
        op_b1[2] = qmr_pkg::opnd_t'(b_y);
        op_b1[3] = qmr_pkg::opnd_t'(b_z);
    end

    qmr_prod u_prod1 (
        .clk  (clk),
        .en   (en1),
        .a    (op_a1),
        .b    (op_b1),
        .prod (prod1)
    );

    qmr_rsum u_rsum1 (
        .clk  (clk),
        .en   (en2),
        .prod (prod1),
        .res  (t),
        .sat  (sat1)
    );

    // second pass: t * conj(a), negation exact in the wider operand
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            op_a2[k] = qmr_pkg::opnd_t'(t[k]);
        end
        op_b2[0] = qmr_pkg::opnd_t'(a2_reg[0]);
        for (int k = 1; k < 4; k++)
        begin
            op_b2[k] = -qmr_pkg::opnd_t'(a2_reg[k]);
        end
    end

    qmr_prod u_prod2 (
        .clk  (clk),
        .en   (en3),
        .a    (op_a2),
        .b    (op_b2),
        .prod (prod2)
    );

    qmr_rsum u_rsum2 (
        .clk  (clk),
        .en   (en4),
        .prod (prod2),
        .res  (r2),
        .sat  (sat2)
    );

    // sideband that travels with each item
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            cmd1_reg  <= cmd;
            a1_reg[0] <= a_w;
            a1_reg[1] <= a_x;
            a1_reg[2] <= a_y;
            a1_reg[3] <= a_z;
        end
        if (en2)
        begin
            cmd2_reg <= cmd1_reg;
            a2_reg   <= a1_reg;
        end
        if (en3)
        begin
            cmd3_reg   <= cmd2_reg;
            t3_reg     <= t;
            sat1_3_reg <= |sat1;
        end
        if (en4)
        begin
            cmd4_reg   <= cmd3_reg;
            t4_reg     <= t3_reg;
            sat1_4_reg <= sat1_3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign r_w = (cmd4_reg == qmr_pkg::CMD_ROT) ? '0    : t4_reg[0];
    assign r_x = (cmd4_reg == qmr_pkg::CMD_ROT) ? r2[1] : t4_reg[1];
    assign r_y = (cmd4_reg == qmr_pkg::CMD_ROT) ? r2[2] : t4_reg[2];
    assign r_z = (cmd4_reg == qmr_pkg::CMD_ROT) ? r2[3] : t4_reg[3];
    assign saturated = sat1_4_reg
                     | ((cmd4_reg == qmr_pkg::CMD_ROT) & (sat2[1] | sat2[2] | sat2[3]));

    a_rot_scalar_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (cmd4_reg == qmr_pkg::CMD_ROT) |-> r_w == '0)
        else $error("rotate result has nonzero scalar");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg && v2_reg && v3_reg && v4_reg && out_stall)
        else $error("input stalled with a free pipeline slot");

    a_transfer_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v1_reg)
        else $error("accepted item missing from first stage");

endmodule

// File: test/qmr_checker.sv
`timescale 1ns / 100ps

module qmr_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_stall,
    input  logic           cmd,
    input  qmr_pkg::data_t a_w,
    input  qmr_pkg::data_t a_x,
    input  qmr_pkg::data_t a_y,
    input  qmr_pkg::data_t a_z,
    input  qmr_pkg::data_t b_w,
    input  qmr_pkg::data_t b_x,
    input  qmr_pkg::data_t b_y,
    input  qmr_pkg::data_t b_z,
    input  logic           out_valid,
    input  logic           out_stall,
    input  qmr_pkg::data_t r_w,
    input  qmr_pkg::data_t r_x,
    input  qmr_pkg::data_t r_y,
    input  qmr_pkg::data_t r_z,
    input  logic           saturated,
    output int             errors,
    output int             pending,
    output int             rotates_seen,
    output int             results_seen,
    output int             clips_seen
);

    typedef struct packed {
        longint w;
        longint x;
        longint y;
        longint z;
    } quad_t;

    typedef struct packed {
        qmr_pkg::data_t w;
        qmr_pkg::data_t x;
        qmr_pkg::data_t y;
        qmr_pkg::data_t z;
        logic           sat;
    } qresult_t;

    qresult_t predicted_results[$];

    // round half up, then clip to the data range
    function automatic qmr_pkg::data_t round_clip(input longint acc, output logic clip);
        longint v;
        v = (acc + (longint'(1) <<< (qmr_pkg::FB - 1))) >>> qmr_pkg::FB;
        clip = 1'b0;
        if (v > longint'(qmr_pkg::DATA_MAX))
        begin
            clip = 1'b1;
            return qmr_pkg::DATA_MAX;
        end
        if (v < longint'(qmr_pkg::DATA_MIN))
        begin
            clip = 1'b1;
            return qmr_pkg::DATA_MIN;
        end
        return qmr_pkg::data_t'(v);
    endfunction

    // clip bits: [0] w, [1] x, [2] y, [3] z
    function automatic quad_t hamilton(input quad_t p, input quad_t q,
                                       output logic [3:0] clip);
        quad_t r;
        r.w = round_clip(p.w * q.w - p.x * q.x - p.y * q.y - p.z * q.z, clip[0]);
        r.x = round_clip(p.w * q.x + p.x * q.w + p.y * q.z - p.z * q.y, clip[1]);
        r.y = round_clip(p.w * q.y + p.y * q.w + p.z * q.x - p.x * q.z, clip[2]);
        r.z = round_clip(p.w * q.z + p.z * q.w + p.x * q.y - p.y * q.x, clip[3]);
        return r;
    endfunction

    function automatic qresult_t predict_quat_op(input logic op, input quad_t a,
                                                 input quad_t b);
        quad_t       t;
        quad_t       conj_a;
        quad_t       r;
        logic [3:0]  clip1;
        logic [3:0]  clip2;
        qresult_t    res;
        if (op == qmr_pkg::CMD_MUL)
        begin
            r = hamilton(a, b, clip1);
            res.sat = |clip1;
        end
        else
        begin
            b.w = 0;
            t = hamilton(a, b, clip1);
            // negate exactly, the most negative value does not clip
            conj_a = '{a.w, -a.x, -a.y, -a.z};
            r = hamilton(t, conj_a, clip2);
            r.w = 0;
            res.sat = (|clip1) | (|clip2[3:1]);
        end
        res.w = qmr_pkg::data_t'(r.w);
        res.x = qmr_pkg::data_t'(r.x);
        res.y = qmr_pkg::data_t'(r.y);
        res.z = qmr_pkg::data_t'(r.z);
        return res;
    endfunction

    always @(posedge clk)
    begin
        qresult_t exp_res;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predicted_results.push_back(predict_quat_op(cmd,
                    '{longint'(a_w), longint'(a_x), longint'(a_y), longint'(a_z)},
                    '{longint'(b_w), longint'(b_x), longint'(b_y), longint'(b_z)}));
                if (cmd == qmr_pkg::CMD_ROT)
                    rotates_seen++;
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (saturated)
                    clips_seen++;
                if (predicted_results.size() == 0)
                begin
                    $error("result transfer with no item outstanding");
                    errors++;
                end
                else
                begin
                    exp_res = predicted_results.pop_front();
                    if (r_w !== exp_res.w)
                    begin
                        $error("r_w: expected %0d, actual %0d", exp_res.w, r_w);
                        errors++;
                    end
                    if (r_x !== exp_res.x)
                    begin
                        $error("r_x: expected %0d, actual %0d", exp_res.x, r_x);
                        errors++;
                    end
                    if (r_y !== exp_res.y)
                    begin
                        $error("r_y: expected %0d, actual %0d", exp_res.y, r_y);
                        errors++;
                    end
                    if (r_z !== exp_res.z)
                    begin
                        $error("r_z: expected %0d, actual %0d", exp_res.z, r_z);
                        errors++;
                    end
                    if (saturated !== exp_res.sat)
                    begin
                        $error("saturated: expected %0b, actual %0b", exp_res.sat,
                               saturated);
                        errors++;
                    end
                end
            end
            pending = predicted_results.size();
        end
    end

endmodule

// File: test/tb_quaternion_multiply_rotate_core.sv
`timescale 1ns / 100ps

module tb_quaternion_multiply_rotate_core;

    localparam int RESET_CYCLES = 6;
    localparam int ITEMS_PER_PHASE = 534;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        qmr_pkg::data_t w;
        qmr_pkg::data_t x;
        qmr_pkg::data_t y;
        qmr_pkg::data_t z;
    } quat_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    logic           cmd;
    qmr_pkg::data_t a_w, a_x, a_y, a_z;
    qmr_pkg::data_t b_w, b_x, b_y, b_z;
    logic           out_valid;
    logic           out_stall = 1'b0;
    qmr_pkg::data_t r_w, r_x, r_y, r_z;
    logic           saturated;

    int errors;
    int pending;
    int rotates_seen;
    int results_seen;
    int clips_seen;
    int send_idle_pct;
    int stall_pct;
    int cycles = 0;

    quaternion_multiply_rotate_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .a_w       (a_w),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .b_w       (b_w),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .r_w       (r_w),
        .r_x       (r_x),
        .r_y       (r_y),
        .r_z       (r_z),
        .saturated (saturated)
    );

    qmr_checker u_checker (.*);

    always #1 clk = ~clk;

    always @(negedge clk)
    begin
        out_stall = rst_n && ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_quaternion_multiply_rotate_core failed");
            $finish;
        end
    end

    // one transfer on the input channel, with random idle cycles ahead of it
    task automatic send_quat_op(input logic op, input quat_t qa, input quat_t qb);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        cmd = op;
        {a_w, a_x, a_y, a_z} = qa;
        {b_w, b_x, b_y, b_z} = qb;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    function automatic qmr_pkg::data_t pick_component(input int style);
        case (style)
            0: return qmr_pkg::data_t'($urandom);
            1: return qmr_pkg::data_t'($urandom_range(32767) - 16384);
            default:
                case ($urandom_range(7))
                    0: return qmr_pkg::DATA_MIN;
                    1: return qmr_pkg::DATA_MAX;
                    2: return qmr_pkg::data_t'(0);
                    3: return qmr_pkg::data_t'(1);
                    4: return qmr_pkg::data_t'(-1);
                    5: return qmr_pkg::data_t'(16384);
                    6: return qmr_pkg::data_t'(-16384);
                    default: return qmr_pkg::data_t'($urandom);
                endcase
        endcase
    endfunction

    function automatic quat_t pick_quat(input int style);
        return '{pick_component(style), pick_component(style),
                 pick_component(style), pick_component(style)};
    endfunction

    // random direction scaled to unit length in Q2.14
    function automatic quat_t unit_quat();
        real qw, qx, qy, qz, n;
        qw = real'(int'($urandom_range(65535)) - 32768);
        qx = real'(int'($urandom_range(65535)) - 32768);
        qy = real'(int'($urandom_range(65535)) - 32768);
        qz = real'(int'($urandom_range(65535)) - 32768);
        n = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
        if (n < 1.0)
            return '{qmr_pkg::data_t'(16384), qmr_pkg::data_t'(0),
                     qmr_pkg::data_t'(0), qmr_pkg::data_t'(0)};
        return '{qmr_pkg::data_t'($rtoi(qw * 16384.0 / n)),
                 qmr_pkg::data_t'($rtoi(qx * 16384.0 / n)),
                 qmr_pkg::data_t'($rtoi(qy * 16384.0 / n)),
                 qmr_pkg::data_t'($rtoi(qz * 16384.0 / n))};
    endfunction

    initial
    begin
        quat_t qa, qb;
        int    sel;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = qmr_pkg::CMD_MUL;
        {a_w, a_x, a_y, a_z} = '0;
        {b_w, b_x, b_y, b_z} = '0;
        send_idle_pct = 16;
        stall_pct = 58;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // products: zero, identity, extremes, half-LSB ties, basis units
        send_quat_op(qmr_pkg::CMD_MUL, '0, '0);
        send_quat_op(qmr_pkg::CMD_MUL, '{16'sd16384, 16'sd0, 16'sd0, 16'sd0},
                     '{16'sd1000, -16'sd2000, 16'sd3000, -16'sd4000});
        send_quat_op(qmr_pkg::CMD_MUL, {4{qmr_pkg::DATA_MAX}}, {4{qmr_pkg::DATA_MAX}});
        send_quat_op(qmr_pkg::CMD_MUL, {4{qmr_pkg::DATA_MIN}}, {4{qmr_pkg::DATA_MIN}});
        send_quat_op(qmr_pkg::CMD_MUL, {4{qmr_pkg::DATA_MAX}}, {4{qmr_pkg::DATA_MIN}});
        send_quat_op(qmr_pkg::CMD_MUL,
                     {qmr_pkg::DATA_MIN, qmr_pkg::DATA_MIN, qmr_pkg::DATA_MIN,
                      qmr_pkg::DATA_MIN},
                     {4{16'shffff}});
        send_quat_op(qmr_pkg::CMD_MUL, '{16'sd1, 16'sd0, 16'sd0, 16'sd0},
                     '{16'sd8192, 16'sd0, 16'sd0, 16'sd0});
        send_quat_op(qmr_pkg::CMD_MUL, '{-16'sd1, 16'sd0, 16'sd0, 16'sd0},
                     '{16'sd8192, 16'sd0, 16'sd0, 16'sd0});
        send_quat_op(qmr_pkg::CMD_MUL, '{16'sd0, 16'sd16384, 16'sd0, 16'sd0},
                     '{16'sd0, 16'sd0, 16'sd16384, 16'sd0});
        send_quat_op(qmr_pkg::CMD_MUL, '0, {4{qmr_pkg::DATA_MAX}});
        // rotations: identity, quarter turn, clipped intermediate, exact
        // conjugate of the most negative value, non-unit scaling, zero a
        send_quat_op(qmr_pkg::CMD_ROT, '{16'sd16384, 16'sd0, 16'sd0, 16'sd0},
                     '{qmr_pkg::DATA_MAX, 16'sd5000, -16'sd6000, 16'sd7000});
        send_quat_op(qmr_pkg::CMD_ROT, '{16'sd11585, 16'sd0, 16'sd0, 16'sd11585},
                     '{16'sd0, 16'sd16384, 16'sd0, 16'sd0});
        send_quat_op(qmr_pkg::CMD_ROT, {4{qmr_pkg::DATA_MIN}}, {4{qmr_pkg::DATA_MIN}});
        send_quat_op(qmr_pkg::CMD_ROT, '{16'sd0, qmr_pkg::DATA_MIN, 16'sd0, 16'sd0},
                     '{16'sd0, 16'sd16384, 16'sd16384, 16'sd16384});
        send_quat_op(qmr_pkg::CMD_ROT, '{qmr_pkg::DATA_MAX, 16'sd0, 16'sd0, 16'sd0},
                     '{16'sd0, 16'sd16384, -16'sd16384, 16'sd1});
        send_quat_op(qmr_pkg::CMD_ROT, '0, {4{qmr_pkg::DATA_MAX}});
        send_quat_op(qmr_pkg::CMD_ROT, {4{qmr_pkg::DATA_MAX}}, {4{qmr_pkg::DATA_MAX}});
        send_quat_op(qmr_pkg::CMD_ROT, '0, '0);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 58 : 0;
            stall_pct     = (phase == 0) ? 58 : (phase == 1) ? 16 : 0;
            repeat (ITEMS_PER_PHASE)
            begin
                sel = $urandom_range(99);
                if (sel < 35)
                begin
                    qa = unit_quat();
                    qb = pick_quat(1);
                end
                else if (sel < 65)
                begin
                    qa = pick_quat(0);
                    qb = pick_quat(0);
                end
                else if (sel < 85)
                begin
                    qa = pick_quat(1);
                    qb = pick_quat(1);
                end
                else
                begin
                    qa = pick_quat(2);
                    qb = pick_quat(2);
                end
                send_quat_op(logic'($urandom_range(1)), qa, qb);
            end
        end
        in_valid = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d results (%0d rotations, %0d with clipping)",
                 results_seen, rotates_seen, clips_seen);
        $display("sender and receiver idled in turn, then ran back to back");
        if (errors == 0)
            $display("tb_quaternion_multiply_rotate_core passed");
        else
            $display("tb_quaternion_multiply_rotate_core failed");
        $finish;
    end

endmodule
